/* src/cak_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cak_pkg
// Shared widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cak_pkg;

   localparam int SEQ_DEPTH     = 8192;
   localparam int PAYLOAD_BYTES = 1024;

   localparam int SEQ_W  = 13;
   localparam int LEN_W  = 11;
   localparam int ACK_W  = 14;

   // received map is kept as rows of ROW_W bits
   localparam int ROW_BITS = 5;
   localparam int ROW_W    = 1 << ROW_BITS;
   localparam int ROWS     = SEQ_DEPTH / ROW_W;
   localparam int ROW_AW   = SEQ_W - ROW_BITS;

   localparam logic [ACK_W-1:0] DEPTH_V   = ACK_W'(SEQ_DEPTH);
   localparam logic [LEN_W-1:0] PAYLOAD_V = LEN_W'(PAYLOAD_BYTES);

   typedef struct packed {
      logic capture;   // latch request fields
      logic rd_seq;    // read map row of the request sequence
      logic modify;    // set the request bit, update highest
      logic rd_walk;   // read map row of next expected
      logic step;      // advance next expected by one
      logic finish;    // resolve completion, load response
   } cmd_type;

   typedef struct packed {
      logic done;      // transfer already complete
      logic req_oor;   // incoming sequence beyond the map
      logic seq_hit;   // latched sequence equals next expected
      logic bit_set;   // map bit at next expected is set
      logic walk_end;  // step reaches map end
      logic row_end;   // step crosses into the next row
   } status_type;

endpackage

/* src/cak_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cak_ctrl
// Sequencer: map read-modify-write, then the walk over contiguous entries.
// ----------------------------------------------------------------------------
module cak_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  cak_pkg::status_type status,
   output cak_pkg::cmd_type    cmd,
   output logic                busy
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_READ   = 3'd1;
   localparam logic [2:0] S_MODIFY = 3'd2;
   localparam logic [2:0] S_WRD    = 3'd3;
   localparam logic [2:0] S_WCHK   = 3'd4;
   localparam logic [2:0] S_FINISH = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               if (status.done || status.req_oor) begin
                  state_in = S_FINISH;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.rd_seq = 1'b1;
            state_in   = S_MODIFY;
         end
         S_MODIFY: begin
            cmd.modify = 1'b1;
            state_in   = status.seq_hit ? S_WRD : S_FINISH;
         end
         S_WRD: begin
            cmd.rd_walk = 1'b1;
            state_in    = S_WCHK;
         end
         S_WCHK: begin
            if (status.bit_set) begin
               cmd.step = 1'b1;
               if (status.walk_end) begin
                  state_in = S_FINISH;
               end else if (status.row_end) begin
                  state_in = S_WRD;
               end
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

/* src/cak_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cak_dp
// Received map memory, sequence registers and response register.
// ----------------------------------------------------------------------------
module cak_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  cak_pkg::cmd_type                  cmd,
   output cak_pkg::status_type               status,
   input  logic [cak_pkg::SEQ_W-1:0]         req_seq_number,
   input  logic [cak_pkg::LEN_W-1:0]         req_payload_length,
   input  logic                              req_is_last,
   output logic                              rsp_valid,
   output logic [cak_pkg::ACK_W-1:0]         rsp_ack_number,
   output logic                              rsp_send_ack,
   output logic                              rsp_transfer_done,
   output logic [cak_pkg::LEN_W-1:0]         rsp_final_length,
   output logic [cak_pkg::SEQ_W-1:0]         rsp_highest_seen,
   output logic                              rsp_out_of_range
);

   // map storage, one row read or written per cycle
   logic [cak_pkg::ROW_W-1:0]  map_mem [cak_pkg::ROWS];
   logic [cak_pkg::ROWS-1:0]   row_valid_ff;

   logic [cak_pkg::ROW_W-1:0]  rd_ff;
   logic                       rd_valid_ff;
   logic [cak_pkg::ROW_W-1:0]  row_eff;
   logic [cak_pkg::ROW_W-1:0]  row_set;

   logic [cak_pkg::SEQ_W-1:0]  seq_ff;
   logic [cak_pkg::LEN_W-1:0]  len_ff;
   logic                       last_ff;
   logic                       oor_ff;

   logic [cak_pkg::ACK_W-1:0]  next_exp_ff;
   logic [cak_pkg::SEQ_W-1:0]  highest_ff;
   logic                       done_ff;
   logic [cak_pkg::LEN_W-1:0]  last_len_ff;

   logic                       rsp_valid_ff;
   logic [cak_pkg::ACK_W-1:0]  rsp_ack_ff;
   logic                       rsp_send_ff;
   logic                       rsp_done_ff;
   logic [cak_pkg::LEN_W-1:0]  rsp_final_ff;
   logic [cak_pkg::SEQ_W-1:0]  rsp_high_ff;
   logic                       rsp_oor_ff;

   logic [cak_pkg::ROW_AW-1:0] rd_addr;
   logic [cak_pkg::ACK_W-1:0]  next_exp_inc;
   logic                       complete;
   logic [cak_pkg::LEN_W-1:0]  len_sat;

   assign rd_addr = cmd.rd_seq ? seq_ff[cak_pkg::SEQ_W-1:cak_pkg::ROW_BITS]
                               : next_exp_ff[cak_pkg::SEQ_W-1:cak_pkg::ROW_BITS];

   // rows never written read as zero
   assign row_eff = rd_valid_ff ? rd_ff : '0;
   assign row_set = row_eff | (cak_pkg::ROW_W'(1) << seq_ff[cak_pkg::ROW_BITS-1:0]);

   assign next_exp_inc = next_exp_ff + cak_pkg::ACK_W'(1);
   assign complete = last_ff && (next_exp_ff != '0) &&
                     ((next_exp_ff - cak_pkg::ACK_W'(1)) == {1'b0, seq_ff});
   assign len_sat  = (len_ff > cak_pkg::PAYLOAD_V) ? cak_pkg::PAYLOAD_V : len_ff;

   always_comb begin
      status.done     = done_ff;
      status.req_oor  = ({1'b0, req_seq_number} >= cak_pkg::DEPTH_V);
      status.seq_hit  = ({1'b0, seq_ff} == next_exp_ff);
      status.bit_set  = row_eff[next_exp_ff[cak_pkg::ROW_BITS-1:0]];
      status.walk_end = (next_exp_inc == cak_pkg::DEPTH_V);
      status.row_end  = (next_exp_ff[cak_pkg::ROW_BITS-1:0] == '1);
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_seq || cmd.rd_walk) begin
         rd_ff       <= map_mem[rd_addr];
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
      if (cmd.modify) begin
         map_mem[seq_ff[cak_pkg::SEQ_W-1:cak_pkg::ROW_BITS]] <= row_set;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         seq_ff  <= req_seq_number;
         len_ff  <= req_payload_length;
         last_ff <= req_is_last;
         oor_ff  <= status.req_oor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         next_exp_ff  <= '0;
         highest_ff   <= '0;
         done_ff      <= 1'b0;
         last_len_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         if (cmd.modify) begin
            row_valid_ff[seq_ff[cak_pkg::SEQ_W-1:cak_pkg::ROW_BITS]] <= 1'b1;
            if (seq_ff > highest_ff) begin
               highest_ff <= seq_ff;
            end
         end
         if (cmd.step) begin
            next_exp_ff <= next_exp_inc;
         end
         if (cmd.finish && !done_ff && !oor_ff && complete) begin
            done_ff     <= 1'b1;
            last_len_ff <= len_sat;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ack_ff  <= next_exp_ff;
         rsp_high_ff <= highest_ff;
         if (done_ff) begin
            rsp_send_ff  <= 1'b0;
            rsp_done_ff  <= 1'b1;
            rsp_final_ff <= last_len_ff;
            rsp_oor_ff   <= 1'b0;
         end else if (oor_ff) begin
            rsp_send_ff  <= 1'b1;
            rsp_done_ff  <= 1'b0;
            rsp_final_ff <= '0;
            rsp_oor_ff   <= 1'b1;
         end else if (complete) begin
            rsp_send_ff  <= 1'b0;
            rsp_done_ff  <= 1'b1;
            rsp_final_ff <= len_sat;
            rsp_oor_ff   <= 1'b0;
         end else begin
            rsp_send_ff  <= 1'b1;
            rsp_done_ff  <= 1'b0;
            rsp_final_ff <= '0;
            rsp_oor_ff   <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ack_number    = rsp_ack_ff;
   assign rsp_send_ack      = rsp_send_ff;
   assign rsp_transfer_done = rsp_done_ff;
   assign rsp_final_length  = rsp_final_ff;
   assign rsp_highest_seen  = rsp_high_ff;
   assign rsp_out_of_range  = rsp_oor_ff;

endmodule

/* src/cumulative_ack_receiver_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cumulative_ack_receiver_unit
// Receiver side of a selective-repeat transfer answering with cumulative acks.
// ----------------------------------------------------------------------------
// Usage:
//   A request (one packet header: sequence number, payload length, last
//   flag) is taken at a rising edge with start high and busy low. Exactly one
//   response follows, shown for a single cycle with rsp_valid high; the
//   receiver cannot stall it, so it must take it in that cycle.
//   A request whose sequence is not next expected passes S_READ, S_MODIFY
//   and S_FINISH. One that matches runs the walk: S_WRD reads the map row
//   of next expected and S_WCHK steps over set entries, back to S_WRD at
//   each 32-entry row boundary, until a clear bit or the map end, then
//   S_FINISH. Requests after completion, or with an out-of-range sequence,
//   go from accept straight to S_FINISH. The walk steps one bit per cycle
//   from a registered row read, save for the row reread at each boundary;
//   busy stays high until the response is loaded, and a new request may be
//   accepted in the cycle the response is shown.
//   Reset clears the expected/highest counters, the done flag and the
//   per-row valid bits of the map (256 flops), so the map reads as all zero
//   with no clearing pass; the block takes requests right after reset.
// ----------------------------------------------------------------------------
module cumulative_ack_receiver_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [cak_pkg::SEQ_W-1:0] req_seq_number,
   input  logic [cak_pkg::LEN_W-1:0] req_payload_length,
   input  logic                      req_is_last,
   output logic                      rsp_valid,
   output logic [cak_pkg::ACK_W-1:0] rsp_ack_number,
   output logic                      rsp_send_ack,
   output logic                      rsp_transfer_done,
   output logic [cak_pkg::LEN_W-1:0] rsp_final_length,
   output logic [cak_pkg::SEQ_W-1:0] rsp_highest_seen,
   output logic                      rsp_out_of_range
);

   cak_pkg::cmd_type    cmd;
   cak_pkg::status_type status;

   // sequencer: read-modify-write of the map row, then the contiguous walk
   cak_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // map memory, expected/highest counters, response register
   cak_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_seq_number     (req_seq_number),
      .req_payload_length (req_payload_length),
      .req_is_last        (req_is_last),
      .rsp_valid          (rsp_valid),
      .rsp_ack_number     (rsp_ack_number),
      .rsp_send_ack       (rsp_send_ack),
      .rsp_transfer_done  (rsp_transfer_done),
      .rsp_final_length   (rsp_final_length),
      .rsp_highest_seen   (rsp_highest_seen),
      .rsp_out_of_range   (rsp_out_of_range)
   );

endmodule
